// ===== hdl/pn3d_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers for the 3D gradient noise block.
// Holds the standard permutation, the gradient selector and the Q16 blend.
// Has no dependencies.
package pn3d_pkg;

  localparam int TBL_SIZE   = 256;
  localparam int TBL_DEPTH  = 2 * TBL_SIZE;
  localparam int TBL_AW     = 9;
  localparam int NUM_COPIES = 7;

  typedef logic [TBL_AW-1:0] tbl_addr_t;
  typedef logic signed [16:0] offs_t;
  typedef logic signed [18:0] grad_t;
  typedef logic signed [19:0] blend_t;
  typedef logic [16:0] fade_t;

  localparam logic [7:0] STD_PERM [TBL_SIZE] = '{
    8'd151, 8'd160, 8'd137, 8'd91, 8'd90, 8'd15, 8'd131, 8'd13, 8'd201, 8'd95, 8'd96,
    8'd53, 8'd194, 8'd233, 8'd7, 8'd225, 8'd140, 8'd36, 8'd103, 8'd30, 8'd69, 8'd142,
    8'd8, 8'd99, 8'd37, 8'd240, 8'd21, 8'd10, 8'd23, 8'd190, 8'd6, 8'd148, 8'd247,
    8'd120, 8'd234, 8'd75, 8'd0, 8'd26, 8'd197, 8'd62, 8'd94, 8'd252, 8'd219, 8'd203,
    8'd117, 8'd35, 8'd11, 8'd32, 8'd57, 8'd177, 8'd33, 8'd88, 8'd237, 8'd149, 8'd56,
    8'd87, 8'd174, 8'd20, 8'd125, 8'd136, 8'd171, 8'd168, 8'd68, 8'd175, 8'd74, 8'd165,
    8'd71, 8'd134, 8'd139, 8'd48, 8'd27, 8'd166, 8'd77, 8'd146, 8'd158, 8'd231, 8'd83,
    8'd111, 8'd229, 8'd122, 8'd60, 8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92, 8'd41,
    8'd55, 8'd46, 8'd245, 8'd40, 8'd244, 8'd102, 8'd143, 8'd54, 8'd65, 8'd25, 8'd63,
    8'd161, 8'd1, 8'd216, 8'd80, 8'd73, 8'd209, 8'd76, 8'd132, 8'd187, 8'd208, 8'd89,
    8'd18, 8'd169, 8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86, 8'd164,
    8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3, 8'd64, 8'd52, 8'd217, 8'd226, 8'd250,
    8'd124, 8'd123, 8'd5, 8'd202, 8'd38, 8'd147, 8'd118, 8'd126, 8'd255, 8'd82, 8'd85,
    8'd212, 8'd207, 8'd206, 8'd59, 8'd227, 8'd47, 8'd16, 8'd58, 8'd17, 8'd182, 8'd189,
    8'd28, 8'd42, 8'd223, 8'd183, 8'd170, 8'd213, 8'd119, 8'd248, 8'd152, 8'd2, 8'd44,
    8'd154, 8'd163, 8'd70, 8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43, 8'd172, 8'd9,
    8'd129, 8'd22, 8'd39, 8'd253, 8'd19, 8'd98, 8'd108, 8'd110, 8'd79, 8'd113, 8'd224,
    8'd232, 8'd178, 8'd185, 8'd112, 8'd104, 8'd218, 8'd246, 8'd97, 8'd228, 8'd251, 8'd34,
    8'd242, 8'd193, 8'd238, 8'd210, 8'd144, 8'd12, 8'd191, 8'd179, 8'd162, 8'd241, 8'd81,
    8'd51, 8'd145, 8'd235, 8'd249, 8'd14, 8'd239, 8'd107, 8'd49, 8'd192, 8'd214, 8'd31,
    8'd181, 8'd199, 8'd106, 8'd157, 8'd184, 8'd84, 8'd204, 8'd176, 8'd115, 8'd121, 8'd50,
    8'd45, 8'd127, 8'd4, 8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93, 8'd222, 8'd114,
    8'd67, 8'd29, 8'd24, 8'd72, 8'd243, 8'd141, 8'd128, 8'd195, 8'd78, 8'd66, 8'd215,
    8'd61, 8'd156, 8'd180
  };

  function automatic grad_t grad(input logic [3:0] h, input offs_t x, input offs_t y,
                                 input offs_t z);
    grad_t u;
    grad_t v;
    u = (h < 4'd8) ? grad_t'(x) : grad_t'(y);
    if (h < 4'd4) begin
      v = grad_t'(y);
    end else if (h == 4'd12 || h == 4'd14) begin
      v = grad_t'(x);
    end else begin
      v = grad_t'(z);
    end
    grad = (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  // a + floor(t * (b - a) / 2^16)
  function automatic blend_t lerp(input fade_t t, input blend_t a, input blend_t b);
    logic signed [20:0] diff;
    logic signed [38:0] prod;
    diff = 21'(b) - 21'(a);
    prod = 39'($signed({1'b0, t})) * 39'(diff);
    lerp = a + blend_t'(prod >>> 16);
  endfunction

endpackage

// ===== hdl/perlin_noise_3d.sv =====
`timescale 1ns / 1ps
// Top level of the 3D gradient noise block: permutation table copies, table
// rebuild sequencer and the seven-stage evaluation pipeline. Uses pn3d_pkg.
//
// Usage: a request on the input channel (in_valid/in_ready) carries one point
// coord_x, coord_y, coord_z in signed fixed point with FRAC_BITS fraction bits.
// The result noise_value (signed Q2.16, saturated) leaves on the output channel
// (out_valid/out_ready) in request order. Throughput is one request per cycle
// while no rebuild or output stall holds it: the table is held in seven
// identical dual-port copies so the three dependent lookup levels each own ports.
// The whole pipeline advances together; when the receiver holds out_ready low
// with a result waiting, every stage holds and in_ready falls.
// Reset loads the standard permutation into all copies, with in_ready low while
// it runs. A write on cfg_we/cfg_data sets the seed and repeats that load; for
// a nonzero seed a shuffle follows, visiting each table position in turn with a
// read, two swap writes and an upper-half write. Write the seed only while idle.
module perlin_noise_3d #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic signed [31:0] coord_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [17:0] noise_value
);

  localparam int DN = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
  localparam int UP = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam logic [31:0] FMASK = 32'((64'd1 << FRAC_BITS) - 64'd1);
  localparam int NC = pn3d_pkg::NUM_COPIES;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FILL = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_WLI  = 3'd3;
  localparam logic [2:0] ST_WLJ  = 3'd4;
  localparam logic [2:0] ST_WUP  = 3'd5;

  logic [2:0]  state;
  logic [8:0]  fill_cnt;
  logic [7:0]  shuf_i;
  logic [7:0]  shuf_j;
  logic [31:0] seed;
  logic        busy;
  logic        adv;

  logic [7:0]           perm_mem [NC][pn3d_pkg::TBL_DEPTH];
  pn3d_pkg::tbl_addr_t  ra [NC];
  pn3d_pkg::tbl_addr_t  rb [NC];
  logic [7:0]           rd_a [NC];
  logic [7:0]           rd_b [NC];
  logic [NC-1:0]        rd_en;
  logic                 tbl_we;
  pn3d_pkg::tbl_addr_t  tbl_waddr;
  logic [7:0]           tbl_wdata;

  logic [7:0]  cx_in, cy_in, cz_in;
  logic [15:0] fx_in, fy_in, fz_in;

  logic        v1, v2, v3, v4, v5, v6;
  logic [7:0]  cy1, cz1, cz2;
  logic [15:0] f1 [3];
  logic [15:0] f2 [3];
  logic [15:0] f3 [3];
  logic [31:0] ff2 [3];
  logic [15:0] d3 [3];
  logic [19:0] bq3 [3];
  pn3d_pkg::fade_t fu4, fv4, fw4, fv5, fw5, fw6;
  pn3d_pkg::grad_t g4 [8];
  pn3d_pkg::blend_t l5 [4];
  pn3d_pkg::blend_t m6 [2];

  pn3d_pkg::tbl_addr_t a1, b1, aa2, ab2, ba2, bb2;
  pn3d_pkg::offs_t x3, y3, z3, x13, y13, z13;
  pn3d_pkg::blend_t r6;
  logic [15:0] d2 [3];
  logic [19:0] bq2 [3];
  pn3d_pkg::fade_t fade3 [3];
  logic [31:0] cd2 [3];
  logic [37:0] bw2 [3];
  logic [35:0] dw3 [3];

  assign busy     = (state != ST_IDLE);
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv && !busy;
  assign shuf_j   = seed[7:0] + (shuf_i << 4) + shuf_i;

  // Table load and seeded shuffle.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_FILL;
      fill_cnt <= '0;
      shuf_i   <= '0;
      seed     <= '0;
    end else if (cfg_we) begin
      state    <= ST_FILL;
      fill_cnt <= '0;
      shuf_i   <= '0;
      seed     <= cfg_data;
    end else begin
      unique case (state)
        ST_IDLE: begin
        end
        ST_FILL: begin
          fill_cnt <= fill_cnt + 9'd1;
          if (fill_cnt == 9'd511) begin
            state <= (seed != 32'd0) ? ST_RD : ST_IDLE;
          end
        end
        ST_RD:  state <= ST_WLI;
        ST_WLI: state <= ST_WLJ;
        ST_WLJ: state <= ST_WUP;
        ST_WUP: begin
          shuf_i <= shuf_i + 8'd1;
          state  <= (shuf_i == 8'd255) ? ST_IDLE : ST_RD;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = '0;
    tbl_wdata = '0;
    unique case (state)
      ST_FILL: begin
        tbl_we    = 1'b1;
        tbl_waddr = fill_cnt;
        tbl_wdata = pn3d_pkg::STD_PERM[fill_cnt[7:0]];
      end
      ST_WLI: begin
        tbl_we    = 1'b1;
        tbl_waddr = {1'b0, shuf_i};
        tbl_wdata = rd_b[0];
      end
      ST_WLJ: begin
        tbl_we    = 1'b1;
        tbl_waddr = {1'b0, shuf_j};
        tbl_wdata = rd_a[0];
      end
      ST_WUP: begin
        tbl_we    = 1'b1;
        tbl_waddr = {1'b1, shuf_i};
        tbl_wdata = rd_b[0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NC; k++) begin
      if (tbl_we) begin
        perm_mem[k][tbl_waddr] <= tbl_wdata;
      end
      if (rd_en[k]) begin
        rd_a[k] <= perm_mem[k][ra[k]];
        rd_b[k] <= perm_mem[k][rb[k]];
      end
    end
  end

  // Input split into cell and 16-bit fraction.
  assign cx_in = 8'($unsigned(coord_x) >> FRAC_BITS);
  assign cy_in = 8'($unsigned(coord_y) >> FRAC_BITS);
  assign cz_in = 8'($unsigned(coord_z) >> FRAC_BITS);
  assign fx_in = 16'((($unsigned(coord_x) & FMASK) >> DN) << UP);
  assign fy_in = 16'((($unsigned(coord_y) & FMASK) >> DN) << UP);
  assign fz_in = 16'((($unsigned(coord_z) & FMASK) >> DN) << UP);

  assign a1  = pn3d_pkg::tbl_addr_t'(rd_a[0]) + pn3d_pkg::tbl_addr_t'(cy1);
  assign b1  = pn3d_pkg::tbl_addr_t'(rd_b[0]) + pn3d_pkg::tbl_addr_t'(cy1);
  assign aa2 = pn3d_pkg::tbl_addr_t'(rd_a[1]) + pn3d_pkg::tbl_addr_t'(cz2);
  assign ab2 = pn3d_pkg::tbl_addr_t'(rd_b[1]) + pn3d_pkg::tbl_addr_t'(cz2);
  assign ba2 = pn3d_pkg::tbl_addr_t'(rd_a[2]) + pn3d_pkg::tbl_addr_t'(cz2);
  assign bb2 = pn3d_pkg::tbl_addr_t'(rd_b[2]) + pn3d_pkg::tbl_addr_t'(cz2);

  always_comb begin
    rd_en    = {NC{adv}};
    rd_en[0] = busy ? (state == ST_RD) : adv;
    ra[0] = busy ? {1'b0, shuf_i} : pn3d_pkg::tbl_addr_t'(cx_in);
    rb[0] = busy ? {1'b0, shuf_j} : pn3d_pkg::tbl_addr_t'(cx_in) + 9'd1;
    ra[1] = a1;
    rb[1] = a1 + 9'd1;
    ra[2] = b1;
    rb[2] = b1 + 9'd1;
    ra[3] = aa2;
    rb[3] = aa2 + 9'd1;
    ra[4] = ab2;
    rb[4] = ab2 + 9'd1;
    ra[5] = ba2;
    rb[5] = ba2 + 9'd1;
    ra[6] = bb2;
    rb[6] = bb2 + 9'd1;
  end

  // Fade polynomial pieces.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cd2[k]   = 32'(ff2[k][31:16]) * 32'(f2[k]);
      d2[k]    = cd2[k][31:16];
      bw2[k]   = 38'(ff2[k]) * 38'd6 + (38'd10 << 32) - ((38'(f2[k]) * 38'd15) << 16);
      bq2[k]   = 20'(bw2[k] >> 16);
      dw3[k]   = 36'(d3[k]) * 36'(bq3[k]);
      fade3[k] = pn3d_pkg::fade_t'(dw3[k] >> 16);
    end
  end

  assign x3  = pn3d_pkg::offs_t'({1'b0, f3[0]});
  assign y3  = pn3d_pkg::offs_t'({1'b0, f3[1]});
  assign z3  = pn3d_pkg::offs_t'({1'b0, f3[2]});
  assign x13 = x3 - 17'sd65536;
  assign y13 = y3 - 17'sd65536;
  assign z13 = z3 - 17'sd65536;

  assign r6 = pn3d_pkg::lerp(fw6, m6[0], m6[1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid && in_ready;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      out_valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cy1   <= cy_in;
      cz1   <= cz_in;
      f1[0] <= fx_in;
      f1[1] <= fy_in;
      f1[2] <= fz_in;
      cz2   <= cz1;
      for (int k = 0; k < 3; k++) begin
        f2[k]  <= f1[k];
        ff2[k] <= 32'(f1[k]) * 32'(f1[k]);
        f3[k]  <= f2[k];
        d3[k]  <= d2[k];
        bq3[k] <= bq2[k];
      end
      g4[0] <= pn3d_pkg::grad(rd_a[3][3:0], x3, y3, z3);
      g4[1] <= pn3d_pkg::grad(rd_a[5][3:0], x13, y3, z3);
      g4[2] <= pn3d_pkg::grad(rd_a[4][3:0], x3, y13, z3);
      g4[3] <= pn3d_pkg::grad(rd_a[6][3:0], x13, y13, z3);
      g4[4] <= pn3d_pkg::grad(rd_b[3][3:0], x3, y3, z13);
      g4[5] <= pn3d_pkg::grad(rd_b[5][3:0], x13, y3, z13);
      g4[6] <= pn3d_pkg::grad(rd_b[4][3:0], x3, y13, z13);
      g4[7] <= pn3d_pkg::grad(rd_b[6][3:0], x13, y13, z13);
      fu4 <= fade3[0];
      fv4 <= fade3[1];
      fw4 <= fade3[2];
      for (int k = 0; k < 4; k++) begin
        l5[k] <= pn3d_pkg::lerp(fu4, pn3d_pkg::blend_t'(g4[2*k]),
                                pn3d_pkg::blend_t'(g4[2*k+1]));
      end
      fv5   <= fv4;
      fw5   <= fw4;
      m6[0] <= pn3d_pkg::lerp(fv5, l5[0], l5[1]);
      m6[1] <= pn3d_pkg::lerp(fv5, l5[2], l5[3]);
      fw6   <= fw5;
      if (r6 > 20'sd131071) begin
        noise_value <= 18'sh1FFFF;
      end else if (r6 < -20'sd131072) begin
        noise_value <= 18'sh20000;
      end else begin
        noise_value <= r6[17:0];
      end
    end
  end

  a_busy_blocks: assert property (@(posedge clk) disable iff (rst) busy |-> !in_ready)
    else $error("request accepted while the table is being rebuilt");
  a_cfg_rebuild: assert property (@(posedge clk) disable iff (rst) cfg_we |=> busy)
    else $error("seed write did not start a table rebuild");
  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !busy |-> in_ready)
    else $error("input stalled with an empty output register");

endmodule

// ===== tb/tb_perlin_noise_3d.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for perlin_noise_3d: random and directed sample points,
// seed changes, and a Q16 noise predictor checked against every result.
// Depends on pn3d_pkg and the perlin_noise_3d RTL.
module tb_perlin_noise_3d;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] coord_x = '0;
  logic signed [31:0] coord_y = '0;
  logic signed [31:0] coord_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [17:0] noise_value;

  perlin_noise_3d DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .out_valid(out_valid), .out_ready(out_ready), .noise_value(noise_value)
  );

  point_t pending_points[$];
  logic signed [17:0] expected_noise[$];
  logic [7:0] perm[512];
  int errors = 0;
  int sent = 0;
  int received = 0;
  longint cycles = 0;
  int send_gap = 0;
  int hold_cycles = 0;
  int recv_gap = 0;
  bit send_pause = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic void load_perm(input logic [31:0] s);
    logic [7:0] t;
    int j;
    for (int i = 0; i < 256; i++) begin
      perm[i] = pn3d_pkg::STD_PERM[i];
      perm[256 + i] = pn3d_pkg::STD_PERM[i];
    end
    if (s != 0) begin
      for (int i = 0; i < 256; i++) begin
        j = (s + i * 17) & 255;
        t = perm[i];
        perm[i] = perm[j];
        perm[j] = t;
        perm[256 + i] = perm[i];
      end
    end
  endfunction

  function automatic int lookup(input int idx);
    return perm[idx & 511];
  endfunction

  function automatic longint floor16(input longint v);
    return v >>> 16;
  endfunction

  function automatic longint fade(input longint f);
    longint c, d, b;
    c = (f * f) >> 16;
    d = (c * f) >> 16;
    b = (6 * f * f + (longint'(10) << 32) - ((15 * f) << 16)) >> 16;
    return (d * b) >> 16;
  endfunction

  function automatic longint mix(input longint t, input longint a, input longint b);
    return a + floor16(t * (b - a));
  endfunction

  function automatic longint slope(input int hash, input longint x, input longint y,
                                   input longint z);
    int h;
    longint u, v;
    h = hash & 15;
    u = (h < 8) ? x : y;
    v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic logic signed [17:0] noise_at(input point_t p);
    int cx, cy, cz, a, aa, ab, b, ba, bb;
    longint x, y, z, x1, y1, z1, u, v, w, r;
    cx = (p.x >> 16) & 255;
    cy = (p.y >> 16) & 255;
    cz = (p.z >> 16) & 255;
    x = p.x[15:0];
    y = p.y[15:0];
    z = p.z[15:0];
    x1 = x - 65536;
    y1 = y - 65536;
    z1 = z - 65536;
    u = fade(x);
    v = fade(y);
    w = fade(z);
    a = lookup(cx) + cy;
    aa = lookup(a) + cz;
    ab = lookup(a + 1) + cz;
    b = lookup(cx + 1) + cy;
    ba = lookup(b) + cz;
    bb = lookup(b + 1) + cz;
    r = mix(w,
      mix(v, mix(u, slope(lookup(aa), x, y, z), slope(lookup(ba), x1, y, z)),
             mix(u, slope(lookup(ab), x, y1, z), slope(lookup(bb), x1, y1, z))),
      mix(v, mix(u, slope(lookup(aa + 1), x, y, z1), slope(lookup(ba + 1), x1, y, z1)),
             mix(u, slope(lookup(ab + 1), x, y1, z1), slope(lookup(bb + 1), x1, y1, z1))));
    if (r > 131071) r = 131071;
    if (r < -131072) r = -131072;
    return r[17:0];
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return {$urandom_range(0, 3) == 0 ? 16'hFFFF : 16'h0000, 16'($urandom)};
      2: return {16'($urandom_range(0, 3)), 16'($urandom)};
      3: return {16'($urandom), $urandom_range(0, 1) ? 16'hFFFF : 16'h0000};
      default: return {16'(int'($urandom_range(0, 8)) - 4), 16'($urandom)};
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        sent <= sent + 1;
        expected_noise.push_back(noise_at({coord_x, coord_y, coord_z}));
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_points.size() > 0 && !send_pause) begin
          point_t p;
          p = pending_points.pop_front();
          in_valid <= 1'b1;
          coord_x <= p.x;
          coord_y <= p.y;
          coord_z <= p.z;
          if ($urandom_range(0, 3) == 0)
            send_gap <= ($urandom_range(0, 15) == 0) ? $urandom_range(5, 40)
                                                      : $urandom_range(1, 3);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // The receiver stops for a long stretch once, while requests keep coming.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        received <= received + 1;
        if (expected_noise.size() == 0) begin
          $error("noise_value: unexpected result %0d", noise_value);
          errors++;
        end else begin
          logic signed [17:0] want;
          want = expected_noise.pop_front();
          if (want !== noise_value) begin
            $error("noise_value: expected %0d, actual %0d", want, noise_value);
            errors++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ready <= 1'b0;
      end else if (out_valid && out_ready && received == 400) begin
        hold_cycles <= 200;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 4) == 0)
          recv_gap <= ($urandom_range(0, 15) == 0) ? $urandom_range(5, 40)
                                                    : $urandom_range(1, 3);
      end
    end
  end

  task automatic run_phase(input logic [31:0] seed, input int count, input bit edges);
    logic [31:0] ext[6];
    ext = '{32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_FFFF,
            32'hFFFF_0000};
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= seed;
    load_perm(seed);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (edges) begin
      for (int i = 0; i < 6; i++) pending_points.push_back({ext[i], ext[i], ext[i]});
      for (int i = 0; i < 12; i++)
        pending_points.push_back({ext[$urandom_range(0, 5)], ext[$urandom_range(0, 5)],
                                  ext[$urandom_range(0, 5)]});
      pending_points.push_back({32'h0001_8000, 32'h0, 32'h0});
      pending_points.push_back({32'h00FF_8000, 32'h0100_4000, 32'h0});
    end
    for (int i = 0; i < count; i++)
      pending_points.push_back({rand_coord(), rand_coord(), rand_coord()});
    wait (pending_points.size() == 0 && !in_valid && expected_noise.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    run_phase(32'h0, 300, 1);
    run_phase(32'hFFFF_FFFF, 250, 1);
    send_pause = 1;
    run_phase(32'h0000_0001, 0, 0);
    send_pause = 0;
    run_phase(32'h8000_0000, 250, 0);
    run_phase($urandom, 250, 0);
    run_phase(32'h0, 150, 0);
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_noise.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
